>>> hw/rtl/wdsk_pkg.sv
`timescale 1ns / 1ps

package wdsk_pkg;

  localparam int MAX_LEN_DEF = 4096;
  localparam int MAX_DEGREE  = 8;
  localparam int KD_W        = 4;
  localparam int WD_W        = 7;
  localparam int SYM_W       = 8;
  localparam int SCORE_W     = 22;
  localparam int SIM_W       = 17;
  localparam int FRAC_W      = 16;
  localparam int TERM_W      = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_DEGREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DEGREE = 1'b1;

  localparam logic [SCORE_W-1:0] SCORE_CAP = 22'd2097152;
  localparam logic [SIM_W-1:0]   Q16_ONE   = 17'd65536;

  // m*(m-1)/2 for a capped run length
  function automatic logic [TERM_W-1:0] tri_num(input logic [KD_W-1:0] m);
    logic [TERM_W-1:0] r;
    unique case (m)
      4'd2:    r = 10'd1;
      4'd3:    r = 10'd3;
      4'd4:    r = 10'd6;
      4'd5:    r = 10'd10;
      4'd6:    r = 10'd15;
      4'd7:    r = 10'd21;
      4'd8:    r = 10'd28;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/weighted_degree_string_kernel_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata                               tuser / tlast
// in_      in   [7:0] symbol_a, [15:8] symbol_b     tlast = last_pair
// out_     out  [21:0] running_score,               tuser [0] final_valid,
//               [38:22] similarity                  [1] length_error
// cfg_     in   cfg_index 0 kernel_degree, 1 weight_degree, data in cfg_wdata
//
// One item at a time: accept, an update step through the shared multiplier,
// then the result waits in the output register. Last pair: a multiply-accumulate
// over d products for the denominator, then a 16-bit restoring division,
// skipped when the quotient caps at 1.0 (d = effective degree, at most 8).
// in_tready is low until the result transfer completes; out stalls hold all.
// rst_n is synchronous, active low; registers come back as degree 1, weight 1.
module weighted_degree_string_kernel_unit #(
  parameter int MAX_LEN = wdsk_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wdsk_pkg::IN_DATA_W-1:0]      in_tdata,   // symbol_a, symbol_b
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wdsk_pkg::OUT_DATA_W-1:0]     out_tdata,  // running_score, similarity
  output logic [wdsk_pkg::OUT_USER_W-1:0]     out_tuser,  // final_valid, length_error
  input  logic                                cfg_we,
  input  logic [wdsk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wdsk_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import wdsk_pkg::*;

  localparam int PC_W  = $clog2(MAX_LEN + 2);
  localparam int MUL_W = PC_W + WD_W;
  localparam int DEN_W = MUL_W + 3;
  localparam int REM_W = ((SCORE_W > DEN_W) ? SCORE_W : DEN_W) + 1;
  localparam logic [PC_W-1:0] LEN_MAX  = PC_W'(MAX_LEN);
  localparam logic [PC_W-1:0] LEN_OVER = PC_W'(MAX_LEN + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_DEN  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [KD_W-1:0]    kd_r, kd_nxt;
  logic [WD_W-1:0]    wd_r, wd_nxt;
  logic [KD_W-1:0]    run_r, run_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [PC_W-1:0]    pos_r, pos_nxt;
  logic               eq_r, eq_nxt;
  logic               last_r, last_nxt;
  logic [PC_W-1:0]    len_r, len_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [FRAC_W-1:0]  quo_r, quo_nxt;
  logic [SCORE_W-1:0] o_score_r, o_score_nxt;
  logic [SIM_W-1:0]   o_sim_r, o_sim_nxt;
  logic               o_valid_r, o_valid_nxt;
  logic               o_err_r, o_err_nxt;

  logic [WD_W-1:0]    f_eff;
  logic [KD_W-1:0]    kd_cap;
  logic [KD_W-1:0]    d_eff;
  logic [KD_W-1:0]    m_cap;
  logic [PC_W-1:0]    mul_a;
  logic [WD_W-1:0]    mul_b;
  logic [MUL_W-1:0]   prod;
  logic [TERM_W-1:0]  term;
  logic [SCORE_W:0]   sum_w;
  logic [PC_W-1:0]    pos_upd;
  logic               err_w;
  logic [DEN_W-1:0]   den_acc;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   den_ext;
  logic               rem_ge;

  // effective degrees
  always_comb begin
    f_eff = (wd_r == '0) ? WD_W'(1) : wd_r;
    if (kd_r == '0) begin
      kd_cap = KD_W'(1);
    end else if (kd_r > KD_W'(MAX_DEGREE)) begin
      kd_cap = KD_W'(MAX_DEGREE);
    end else begin
      kd_cap = kd_r;
    end
    d_eff = ({3'b000, kd_cap} > f_eff) ? f_eff[KD_W-1:0] : kd_cap;
    m_cap = (run_r + KD_W'(1) > d_eff) ? d_eff : run_r + KD_W'(1);
  end

  // shared multiplier: run term in CALC, denominator products in DEN
  always_comb begin
    if (state_r == ST_DEN) begin
      mul_a = len_r - PC_W'(step_r[2:0]);
      mul_b = f_eff - WD_W'(step_r[2:0]);
    end else begin
      mul_a = PC_W'(m_cap);
      mul_b = f_eff;
    end
    prod = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  assign term    = prod[TERM_W-1:0] - tri_num(m_cap);
  assign sum_w   = {1'b0, score_r} + (SCORE_W+1)'(term);
  assign den_acc = den_r + DEN_W'(prod);
  assign den_ext = REM_W'(den_r);
  assign rem_sh  = {rem_r[REM_W-2:0], 1'b0};
  assign rem_ge  = rem_sh >= den_ext;

  always_comb begin
    state_nxt   = state_r;
    kd_nxt      = kd_r;
    wd_nxt      = wd_r;
    run_nxt     = run_r;
    score_nxt   = score_r;
    pos_nxt     = pos_r;
    eq_nxt      = eq_r;
    last_nxt    = last_r;
    len_nxt     = len_r;
    step_nxt    = step_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    o_score_nxt = o_score_r;
    o_sim_nxt   = o_sim_r;
    o_valid_nxt = o_valid_r;
    o_err_nxt   = o_err_r;
    pos_upd     = pos_r;
    err_w       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_DEGREE: kd_nxt = cfg_wdata[KD_W-1:0];
        REG_WEIGHT_DEGREE: wd_nxt = cfg_wdata[WD_W-1:0];
        default:           kd_nxt = kd_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          eq_nxt    = in_tdata[SYM_W-1:0] == in_tdata[2*SYM_W-1:SYM_W];
          last_nxt  = in_tlast;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (pos_r < LEN_MAX) begin
          pos_upd = pos_r + PC_W'(1);
          if (eq_r) begin
            run_nxt   = m_cap;
            score_nxt = (sum_w > {1'b0, SCORE_CAP}) ? SCORE_CAP : sum_w[SCORE_W-1:0];
          end else begin
            run_nxt = '0;
          end
        end else begin
          pos_upd = LEN_OVER;
        end
        pos_nxt     = pos_upd;
        err_w       = (pos_upd > LEN_MAX) || (last_r && (pos_upd < PC_W'(d_eff)));
        o_score_nxt = score_nxt;
        o_err_nxt   = err_w;
        o_valid_nxt = 1'b0;
        o_sim_nxt   = '0;
        len_nxt     = pos_upd;
        step_nxt    = '0;
        den_nxt     = '0;
        if (last_r) begin
          run_nxt   = '0;
          score_nxt = '0;
          pos_nxt   = '0;
        end
        state_nxt = (last_r && !err_w) ? ST_DEN : ST_OUT;
      end
      ST_DEN: begin
        den_nxt  = den_acc;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(d_eff - KD_W'(1))) begin
          step_nxt    = '0;
          o_valid_nxt = 1'b1;
          if (REM_W'(o_score_r) >= REM_W'(den_acc)) begin
            o_sim_nxt = Q16_ONE;
            state_nxt = ST_OUT;
          end else begin
            rem_nxt   = REM_W'(o_score_r);
            quo_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? rem_sh - den_ext : rem_sh;
        quo_nxt  = {quo_r[FRAC_W-2:0], rem_ge};
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(FRAC_W - 1)) begin
          o_sim_nxt = {1'b0, quo_nxt};
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kd_r    <= KD_W'(1);
      wd_r    <= WD_W'(1);
      run_r   <= '0;
      score_r <= '0;
      pos_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kd_r    <= kd_nxt;
      wd_r    <= wd_nxt;
      run_r   <= run_nxt;
      score_r <= score_nxt;
      pos_r   <= pos_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eq_r      <= eq_nxt;
    last_r    <= last_nxt;
    len_r     <= len_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    o_score_r <= o_score_nxt;
    o_sim_r   <= o_sim_nxt;
    o_valid_r <= o_valid_nxt;
    o_err_r   <= o_err_nxt;
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = state_r == ST_OUT;
  assign out_tdata  = {1'b0, o_sim_r, o_score_r};
  assign out_tuser  = {o_err_r, o_valid_r};

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output sides open together");

  a_den_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEN) |-> (step_r < 4'(d_eff)))
    else $error("denominator step beyond degree");

  a_valid_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("final value flagged together with length error");

  a_sim_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (o_sim_r == '0))
    else $error("similarity set without final value");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_ext))
    else $error("division remainder not below denominator");

endmodule

>>> sim/weighted_degree_string_kernel_unit_tb.sv
`timescale 1ns / 1ps

module weighted_degree_string_kernel_unit_tb;
  import wdsk_pkg::*;

  localparam int STR_MAX     = MAX_LEN_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PAIRS  = 920;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               fin;
    logic [SIM_W-1:0]   sim;
    logic               err;
  } kernel_result_t;

  class wdsk_score_tracker;
    logic [KD_W-1:0] kernel_degree = 4'd1;
    logic [WD_W-1:0] weight_degree = 7'd1;
    int unsigned run_len   = 0;
    int unsigned score     = 0;
    int unsigned pos_count = 0;
    kernel_result_t score_fifo[$];
    int mismatches   = 0;
    int finals_seen  = 0;
    int errors_seen  = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      if (idx == REG_KERNEL_DEGREE) begin
        kernel_degree = v[KD_W-1:0];
      end else begin
        weight_degree = v[WD_W-1:0];
      end
    endfunction

    function void accept_pair(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b, logic is_last);
      int unsigned f;
      int unsigned d;
      int unsigned m;
      int unsigned term;
      int unsigned sum;
      longint unsigned den;
      longint unsigned q;
      bit err;
      kernel_result_t r;
      f = (weight_degree == 0) ? 1 : weight_degree;
      d = (kernel_degree == 0) ? 1 :
          ((kernel_degree > MAX_DEGREE) ? MAX_DEGREE : kernel_degree);
      if (d > f) d = f;
      if (pos_count < STR_MAX) begin
        pos_count++;
        if (a == b) begin
          m = run_len + 1;
          if (m > d) m = d;
          run_len = m;
          term = m * f - (m * (m - 1)) / 2;
          sum = score + term;
          score = (sum > SCORE_CAP) ? SCORE_CAP : sum;
        end else begin
          run_len = 0;
        end
      end else begin
        pos_count = STR_MAX + 1;
      end
      err = pos_count > STR_MAX;
      if (is_last && pos_count < d) err = 1'b1;
      r.score = score[SCORE_W-1:0];
      r.err = err;
      r.fin = 1'b0;
      r.sim = '0;
      if (is_last && !err) begin
        den = 0;
        for (int i = 0; i < d; i++) den += longint'(pos_count - i) * longint'(f - i);
        q = (den == 0) ? 0 : (longint'(score) * 65536) / den;
        if (q > 65536) q = 65536;
        r.sim = q[SIM_W-1:0];
        r.fin = 1'b1;
      end
      score_fifo.push_back(r);
      if (is_last) begin
        run_len = 0;
        score = 0;
        pos_count = 0;
      end
    endfunction

    function void compare_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      kernel_result_t want;
      logic [SCORE_W-1:0] got_score;
      logic [SIM_W-1:0]   got_sim;
      got_score = data[SCORE_W-1:0];
      got_sim   = data[SCORE_W+SIM_W-1:SCORE_W];
      if (score_fifo.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: score %0d sim %0d final %0b err %0b",
                   got_score, got_sim, user[0], user[1]);
        mismatches++;
        return;
      end
      want = score_fifo.pop_front();
      if (want.fin) finals_seen++;
      if (want.err) errors_seen++;
      if (got_score !== want.score || got_sim !== want.sim ||
          user[0] !== want.fin || user[1] !== want.err) begin
        if (mismatches < 10)
          $display("mismatch: score %0d/%0d sim %0d/%0d final %0b/%0b err %0b/%0b (exp/got)",
                   want.score, got_score, want.sim, got_sim,
                   want.fin, user[0], want.err, user[1]);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return score_fifo.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;   // running_score, similarity
  logic [OUT_USER_W-1:0] out_tuser;   // final_valid, length_error
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  wdsk_score_tracker tracker;
  int cycles = 0;
  int pairs_sent = 0;
  int strings_sent = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  weighted_degree_string_kernel_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, tracker.outstanding());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(8, 80);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.compare_result(out_tdata, out_tuser);
  end

  task automatic send_pair(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b,
                           input logic is_last);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.accept_pair(a, b, is_last);
    pairs_sent++;
    if (is_last) strings_sent++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic settle();
    pause_sender(1);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] wd);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_KERNEL_DEGREE;
    cfg_wdata <= kd;
    @(posedge clk);
    tracker.set_reg(REG_KERNEL_DEGREE, kd);
    cfg_index <= REG_WEIGHT_DEGREE;
    cfg_wdata <= wd;
    @(posedge clk);
    tracker.set_reg(REG_WEIGHT_DEGREE, wd);
    cfg_we <= 1'b0;
    cfg_writes += 2;
  endtask

  task automatic random_config();
    logic [KD_W-1:0] kd;
    logic [WD_W-1:0] wd;
    case ($urandom_range(0, 5))
      0: kd = 4'd0;
      1: kd = 4'd1;
      2: kd = 4'd8;
      3: kd = 4'd15;
      default: kd = KD_W'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 5))
      0: wd = 7'd0;
      1: wd = 7'd1;
      2: wd = 7'd64;
      3: wd = 7'd127;
      default: wd = WD_W'($urandom_range(1, 64));
    endcase
    // upper data bits are don't-care for the kernel degree register
    reconfigure({3'($urandom_range(0, 7)), kd}, wd);
  endtask

  task automatic send_string(input int len, input int match_pct, input bit paced,
                             input bit allow_cfg);
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = SYM_W'($urandom_range(0, 255));
      b = ($urandom_range(0, 99) < match_pct) ? a : 8'($urandom_range(0, 255));
      if (allow_cfg && i != 0 && $urandom_range(0, 59) == 0) random_config();
      if (paced) pace();
      send_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    int start_pairs;
    int len;
    int pct;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: degree 1, weight 1
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'h55, 8'hAA, 1'b0);
    send_pair(8'hAA, 8'hAA, 1'b1);
    // zero registers act as one
    reconfigure(7'd0, 7'd0);
    send_pair(8'h01, 8'h01, 1'b1);
    // degree above 8 clamps, widest weight; all-match string gives 1.0
    reconfigure(7'd15, 7'd127);
    for (int i = 0; i < 9; i++) send_pair(8'(i * 29), 8'(i * 29), i == 8);
    // weight below degree, string shorter than the effective degree
    reconfigure(7'd8, 7'd3);
    send_pair(8'h07, 8'h07, 1'b0);
    send_pair(8'h03, 8'h03, 1'b1);
    reconfigure(7'd8, 7'd64);
    send_pair(8'h00, 8'h00, 1'b1);
    send_pair(8'h80, 8'h7F, 1'b0);
    send_pair(8'hFF, 8'h00, 1'b1);

    start_pairs = pairs_sent;
    while (pairs_sent - start_pairs < RAND_PAIRS) begin
      if ($urandom_range(0, 3) == 0) random_config();
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 3);
        8, 9: len = $urandom_range(41, 200);
        default: len = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0: pct = 100;
        1, 2: pct = 90;
        3: pct = 60;
        4: pct = 30;
        default: pct = 0;
      endcase
      if (!hold_req && pairs_sent - start_pairs > 300) hold_req = 1'b1;
      send_string(len, pct, $urandom_range(0, 4) != 0, 1'b1);
    end

    settle();
    repeat (40) @(posedge clk);
    $display("%0d pairs in %0d strings, %0d config writes, %0d cycles", pairs_sent,
             strings_sent, cfg_writes, cycles);
    $display("%0d normalized finals, %0d length errors, %0d mismatches",
             tracker.finals_seen, tracker.errors_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
